// ===== rtl/core/iee_pkg.sv =====
// Shared types, constants and priority functions of the infix evaluator.
package iee_pkg;

    localparam int STACK_DEPTH  = 16;
    localparam int VALUE_WIDTH  = 32;
    localparam int OUT_WIDTH    = 32;
    localparam int CHAR_WIDTH   = 8;
    localparam int STATUS_WIDTH = 3;
    localparam int PRIO_WIDTH   = 3;
    localparam int ADDR_W       = $clog2(STACK_DEPTH);
    localparam int COUNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W    = $clog2(VALUE_WIDTH + 1);

    localparam logic [CHAR_WIDTH-1:0] ASCII_HASH  = 8'h23;
    localparam logic [CHAR_WIDTH-1:0] ASCII_OPEN  = 8'h28;
    localparam logic [CHAR_WIDTH-1:0] ASCII_CLOSE = 8'h29;
    localparam logic [CHAR_WIDTH-1:0] ASCII_MUL   = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] ASCII_ADD   = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] ASCII_SUB   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] ASCII_DIV   = 8'h2F;
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] ASCII_NINE  = 8'h39;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [2:0] {
        OP_END, OP_OPEN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CLOSE, OP_NONE
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK, ST_UNDER, ST_DIVZERO, ST_OVER, ST_BAD
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DIG_WAIT, S_OPCHK, S_RD_L, S_ALU, S_DIV, S_PUSH,
        S_FIN, S_RES
    } state_t;

    typedef enum logic [1:0] {
        RD_NONE, RD_TOP, RD_SECOND
    } rd_sel_t;

    typedef struct packed {
        logic    load_char;
        logic    val_push;
        logic    val_push_digit;
        logic    val_upd_top;
        logic    val_pop2;
        rd_sel_t rd_sel;
        logic    op_push;
        logic    op_pop;
        logic    err_set;
        status_t err_code;
        logic    num_set;
        logic    num_clr;
        logic    latch_r;
        logic    alu_go;
        logic    div_start;
        logic    div_take;
        logic    emit;
        logic    clear_all;
    } cmd_t;

    typedef struct packed {
        op_t  cls;
        logic is_digit;
        logic in_number;
        logic err_active;
        logic v_empty;
        logic v_lt2;
        logic o_empty;
        op_t  top_op;
        op_t  red_op;
        logic r_zero;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic op_t classify(input logic [CHAR_WIDTH-1:0] c);
        op_t r;
        unique case (c)
            ASCII_HASH:  r = OP_END;
            ASCII_OPEN:  r = OP_OPEN;
            ASCII_CLOSE: r = OP_CLOSE;
            ASCII_ADD:   r = OP_ADD;
            ASCII_SUB:   r = OP_SUB;
            ASCII_MUL:   r = OP_MUL;
            ASCII_DIV:   r = OP_DIV;
            default:     r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [PRIO_WIDTH-1:0] prio_stack(input op_t op);
        logic [PRIO_WIDTH-1:0] p;
        unique case (op)
            OP_OPEN:         p = 3'd1;
            OP_ADD, OP_SUB:  p = 3'd3;
            OP_MUL, OP_DIV:  p = 3'd5;
            OP_CLOSE:        p = 3'd6;
            default:         p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic [PRIO_WIDTH-1:0] prio_in(input op_t op);
        logic [PRIO_WIDTH-1:0] p;
        unique case (op)
            OP_OPEN:         p = 3'd6;
            OP_ADD, OP_SUB:  p = 3'd2;
            OP_MUL, OP_DIV:  p = 3'd4;
            OP_CLOSE:        p = 3'd1;
            default:         p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/iee_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module iee_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  iee_pkg::value_t dividend,
    input  iee_pkg::value_t divisor,
    output iee_pkg::value_t quotient,
    output logic            done
);

    localparam int VW = iee_pkg::VALUE_WIDTH;

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [iee_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    iee_pkg::value_t               quo_reg;
    iee_pkg::value_t               rem_reg;
    iee_pkg::value_t               den_reg;
    logic                          neg_reg;
    logic [VW:0]                   rem_sh;
    logic [VW:0]                   diff;
    logic                          fits;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[VW-1]};
        diff   = rem_sh - {1'b0, den_reg};
        fits   = ~diff[VW];
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = iee_pkg::DIV_CNT_W'(VW);
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - iee_pkg::DIV_CNT_W'(1);
            if (cnt_reg == iee_pkg::DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[VW-1] ? iee_pkg::value_t'(0 - dividend) : dividend;
            den_reg <= divisor[VW-1] ? iee_pkg::value_t'(0 - divisor) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[VW-1] ^ divisor[VW-1];
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[VW-2:0], fits};
            rem_reg <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
        end
    end

    assign quotient = neg_reg ? iee_pkg::value_t'(0 - quo_reg) : quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/iee_dpath.sv =====
// Datapath: value and operator stacks, arithmetic, error and output registers.
module iee_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  iee_pkg::cmd_t                      cmd,
    input  logic [iee_pkg::CHAR_WIDTH-1:0]     char_code,
    input  logic                               out_ready,
    output iee_pkg::sts_t                      sts,
    output logic signed [iee_pkg::OUT_WIDTH-1:0] result_value,
    output logic [iee_pkg::STATUS_WIDTH-1:0]   status,
    output logic                               out_valid
);

    localparam int AW = iee_pkg::ADDR_W;
    localparam int CW = iee_pkg::COUNT_W;

    logic [iee_pkg::CHAR_WIDTH-1:0]       char_reg;
    logic [CW-1:0]                        vc_reg, vc_next;
    logic [CW-1:0]                        oc_reg, oc_next;
    logic                                 num_reg, num_next;
    iee_pkg::status_t                     err_reg, err_next;
    iee_pkg::op_t                         op_reg;
    iee_pkg::value_t                      r_reg;
    iee_pkg::value_t                      res_reg;
    iee_pkg::value_t                      rdata_reg;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [iee_pkg::OUT_WIDTH-1:0] result_reg;
    logic [iee_pkg::STATUS_WIDTH-1:0]     status_reg;

    iee_pkg::value_t val_mem [iee_pkg::STACK_DEPTH];
    iee_pkg::op_t    op_mem  [iee_pkg::STACK_DEPTH];

    logic [CW-1:0]   vc_m1, vc_m2, oc_m1;
    logic            v_full, o_full;
    iee_pkg::op_t    cls;
    iee_pkg::op_t    top_op;
    iee_pkg::value_t digit;
    iee_pkg::value_t res_next;
    iee_pkg::value_t quo;
    logic            div_done;
    logic            vwe;
    logic [AW-1:0]   vwaddr;
    iee_pkg::value_t vwdata;
    logic            rd_en;
    logic [AW-1:0]   raddr;
    logic            op_we;

    assign vc_m1  = vc_reg - CW'(1);
    assign vc_m2  = vc_reg - CW'(2);
    assign oc_m1  = oc_reg - CW'(1);
    assign v_full = (vc_reg >= CW'(iee_pkg::STACK_DEPTH));
    assign o_full = (oc_reg >= CW'(iee_pkg::STACK_DEPTH));
    assign cls    = iee_pkg::classify(char_reg);
    assign digit  = iee_pkg::value_t'(char_reg - iee_pkg::ASCII_ZERO);
    assign top_op = (oc_m1[AW-1:0] == '0) ? iee_pkg::OP_END : op_mem[oc_m1[AW-1:0]];

    iee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rdata_reg),
        .divisor  (r_reg),
        .quotient (quo),
        .done     (div_done)
    );

    always_comb
    begin
        vwe    = cmd.val_upd_top || (cmd.val_push && !v_full);
        vwaddr = vc_reg[AW-1:0];
        vwdata = cmd.val_push_digit ? digit : res_reg;
        if (cmd.val_upd_top)
        begin
            vwaddr = vc_m1[AW-1:0];
            vwdata = (rdata_reg << 3) + (rdata_reg << 1) + digit;
        end
        rd_en = 1'b1;
        raddr = vc_m1[AW-1:0];
        unique case (cmd.rd_sel)
            iee_pkg::RD_TOP:    raddr = vc_m1[AW-1:0];
            iee_pkg::RD_SECOND: raddr = vc_m2[AW-1:0];
            default:            rd_en = 1'b0;
        endcase
        op_we = cmd.op_push && !o_full;
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            val_mem[vwaddr] <= vwdata;
        if (rd_en)
            rdata_reg <= val_mem[raddr];
        if (op_we)
            op_mem[oc_reg[AW-1:0]] <= cls;
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.alu_go)
        begin
            case (op_reg)
                iee_pkg::OP_ADD: res_next = rdata_reg + r_reg;
                iee_pkg::OP_SUB: res_next = rdata_reg - r_reg;
                default:         res_next = iee_pkg::value_t'(rdata_reg * r_reg);
            endcase
        end
        else if (cmd.div_take)
            res_next = quo;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
            char_reg <= char_code;
        if (cmd.op_pop)
            op_reg <= top_op;
        if (cmd.latch_r)
            r_reg <= rdata_reg;
        res_reg <= res_next;
        if (cmd.emit)
        begin
            result_reg <= (err_reg == iee_pkg::ST_OK)
                        ? iee_pkg::OUT_WIDTH'($signed(rdata_reg)) : '0;
            status_reg <= err_reg;
        end
    end

    always_comb
    begin
        vc_next        = vc_reg;
        oc_next        = oc_reg;
        num_next       = num_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        if (cmd.val_push && !v_full)
            vc_next = vc_reg + CW'(1);
        else if (cmd.val_pop2)
            vc_next = vc_m2;
        if (op_we)
            oc_next = oc_reg + CW'(1);
        else if (cmd.op_pop)
            oc_next = oc_m1;
        if (cmd.num_set)
            num_next = 1'b1;
        else if (cmd.num_clr)
            num_next = 1'b0;
        if (err_reg == iee_pkg::ST_OK)
        begin
            if (cmd.err_set)
                err_next = cmd.err_code;
            else if ((cmd.val_push && v_full) || (cmd.op_push && o_full))
                err_next = iee_pkg::ST_OVER;
        end
        if (cmd.clear_all)
        begin
            vc_next  = '0;
            oc_next  = CW'(1);
            num_next = 1'b0;
            err_next = iee_pkg::ST_OK;
        end
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= '0;
            oc_reg        <= CW'(1);
            num_reg       <= 1'b0;
            err_reg       <= iee_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vc_reg        <= vc_next;
            oc_reg        <= oc_next;
            num_reg       <= num_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        sts.cls        = cls;
        sts.is_digit   = (char_reg >= iee_pkg::ASCII_ZERO) && (char_reg <= iee_pkg::ASCII_NINE);
        sts.in_number  = num_reg;
        sts.err_active = (err_reg != iee_pkg::ST_OK);
        sts.v_empty    = (vc_reg == '0);
        sts.v_lt2      = (vc_reg < CW'(2));
        sts.o_empty    = (oc_reg == '0);
        sts.top_op     = top_op;
        sts.red_op     = op_reg;
        sts.r_zero     = (r_reg == '0);
        sts.div_done   = div_done;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign result_value = result_reg;
    assign status       = status_reg;
    assign out_valid    = out_valid_reg;

endmodule

// ===== rtl/core/iee_ctrl.sv =====
// Controller state machine: character dispatch, precedence loop, reduce and emit.
module iee_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  iee_pkg::sts_t sts,
    output iee_pkg::cmd_t cmd,
    output logic          in_ready
);

    iee_pkg::state_t state_reg, state_next;
    iee_pkg::state_t op_exit;
    logic [iee_pkg::PRIO_WIDTH-1:0] ps, pi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iee_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    assign ps      = iee_pkg::prio_stack(sts.top_op);
    assign pi      = iee_pkg::prio_in(sts.cls);
    assign op_exit = (sts.cls == iee_pkg::OP_END) ? iee_pkg::S_FIN : iee_pkg::S_IDLE;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            iee_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_char = 1'b1;
                    state_next    = iee_pkg::S_DISPATCH;
                end
            end
            iee_pkg::S_DISPATCH:
            begin
                if (sts.cls == iee_pkg::OP_END)
                begin
                    cmd.num_clr = 1'b1;
                    state_next  = sts.err_active ? iee_pkg::S_FIN : iee_pkg::S_OPCHK;
                end
                else if (sts.err_active)
                    state_next = iee_pkg::S_IDLE;
                else if (sts.is_digit)
                begin
                    cmd.num_set = 1'b1;
                    if (sts.in_number && !sts.v_empty)
                    begin
                        cmd.rd_sel = iee_pkg::RD_TOP;
                        state_next = iee_pkg::S_DIG_WAIT;
                    end
                    else
                    begin
                        cmd.val_push       = 1'b1;
                        cmd.val_push_digit = 1'b1;
                        state_next         = iee_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.num_clr = 1'b1;
                    if (sts.cls == iee_pkg::OP_NONE)
                    begin
                        cmd.err_set  = 1'b1;
                        cmd.err_code = iee_pkg::ST_BAD;
                        state_next   = iee_pkg::S_IDLE;
                    end
                    else
                        state_next = iee_pkg::S_OPCHK;
                end
            end
            iee_pkg::S_DIG_WAIT:
            begin
                cmd.val_upd_top = 1'b1;
                state_next      = iee_pkg::S_IDLE;
            end
            iee_pkg::S_OPCHK:
            begin
                state_next = op_exit;
                if (sts.err_active)
                    state_next = op_exit;
                else if (sts.o_empty)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = iee_pkg::ST_BAD;
                end
                else if (ps < pi)
                begin
                    if (sts.cls == iee_pkg::OP_CLOSE)
                    begin
                        cmd.err_set  = 1'b1;
                        cmd.err_code = iee_pkg::ST_BAD;
                    end
                    else
                        cmd.op_push = 1'b1;
                end
                else if (ps == pi)
                begin
                    if (sts.cls != iee_pkg::OP_END)
                        cmd.op_pop = 1'b1;
                end
                else if (sts.top_op == iee_pkg::OP_OPEN || sts.top_op == iee_pkg::OP_END)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = iee_pkg::ST_BAD;
                end
                else
                begin
                    cmd.op_pop = 1'b1;
                    if (sts.v_lt2)
                    begin
                        cmd.err_set  = 1'b1;
                        cmd.err_code = iee_pkg::ST_UNDER;
                        state_next   = iee_pkg::S_OPCHK;
                    end
                    else
                    begin
                        cmd.rd_sel = iee_pkg::RD_TOP;
                        state_next = iee_pkg::S_RD_L;
                    end
                end
            end
            iee_pkg::S_RD_L:
            begin
                cmd.latch_r = 1'b1;
                cmd.rd_sel  = iee_pkg::RD_SECOND;
                state_next  = iee_pkg::S_ALU;
            end
            iee_pkg::S_ALU:
            begin
                cmd.val_pop2 = 1'b1;
                case (sts.red_op) inside
                    iee_pkg::OP_ADD, iee_pkg::OP_SUB, iee_pkg::OP_MUL:
                    begin
                        cmd.alu_go = 1'b1;
                        state_next = iee_pkg::S_PUSH;
                    end
                    iee_pkg::OP_DIV:
                    begin
                        if (sts.r_zero)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = iee_pkg::ST_DIVZERO;
                            state_next   = iee_pkg::S_OPCHK;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = iee_pkg::S_DIV;
                        end
                    end
                    default:
                    begin
                        cmd.err_set  = 1'b1;
                        cmd.err_code = iee_pkg::ST_BAD;
                        state_next   = iee_pkg::S_OPCHK;
                    end
                endcase
            end
            iee_pkg::S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = iee_pkg::S_PUSH;
                end
            end
            iee_pkg::S_PUSH:
            begin
                cmd.val_push = 1'b1;
                state_next   = iee_pkg::S_OPCHK;
            end
            iee_pkg::S_FIN:
            begin
                if (!sts.err_active && sts.v_empty)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = iee_pkg::ST_UNDER;
                end
                cmd.rd_sel = iee_pkg::RD_TOP;
                state_next = iee_pkg::S_RES;
            end
            iee_pkg::S_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = iee_pkg::S_IDLE;
                end
            end
            default:
                state_next = iee_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/infix_expression_evaluator.sv =====
// Top level of the infix expression evaluator: controller, datapath and checks.
//
// Input channel: one ASCII character per request on char_code (in_valid/in_ready).
// Digits build a decimal operand, + - * / ( ) are operators, '#' ends the expression.
// Output channel: one request per '#' carrying result_value and status
// (out_valid/out_ready); status 0 ok, 1 underflow, 2 divide by zero, 3 overflow,
// 4 bad character or parenthesis. A nonzero status forces result_value to 0.
// Timing: one request in flight. A digit is loaded and dispatched, with a further
// read-modify-write of the stack top when it extends an operand; an operator is
// loaded and dispatched, then goes through the priority compares; each reduction
// reads both operands, computes and pushes, and a division waits on the
// shift-subtract divider. The '#' request then reads the top of the value stack
// and loads the output register.
// A deep chain of divisions sets the worst case per reduction.
// Reset: stacks empty, operator stack holds only the end marker, no error.
// The block also returns to this state after each '#'.
// Stall: the output register holds a result until taken; the next characters are
// still accepted, and only the following '#' waits for the register to free up.
module infix_expression_evaluator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [iee_pkg::CHAR_WIDTH-1:0]       char_code,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    output logic signed [iee_pkg::OUT_WIDTH-1:0] result_value,
    output logic [iee_pkg::STATUS_WIDTH-1:0]     status,
    output logic                                 out_valid,
    input  logic                                 out_ready
);

    iee_pkg::cmd_t cmd;
    iee_pkg::sts_t sts;

    iee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    iee_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_code    (char_code),
        .out_ready    (out_ready),
        .sts          (sts),
        .result_value (result_value),
        .status       (status),
        .out_valid    (out_valid)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while previous request still in work");

    a_error_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != iee_pkg::STATUS_WIDTH'(iee_pkg::ST_OK)))
            |-> (result_value == '0))
        else $error("nonzero status with nonzero result");

    a_emit_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> !cmd.emit || out_ready)
        else $error("result overwritten while output register stalled");

endmodule

// ===== bench/tb_infix_expression_evaluator.sv =====
// Testbench for the infix expression evaluator: random and directed expressions.
`timescale 1ns / 100ps

module tb_infix_expression_evaluator;

    class expr_scoreboard;
        logic [31:0]      stk_val [16];
        int unsigned      val_cnt;
        iee_pkg::op_t     stk_op [16];
        int unsigned      op_cnt;
        bit               in_num;
        iee_pkg::status_t err;
        logic [31:0]      exp_result [$];
        iee_pkg::status_t exp_status [$];
        int               mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            val_cnt = 0;
            op_cnt = 1;
            stk_op[0] = iee_pkg::OP_END;
            in_num = 0;
            err = iee_pkg::ST_OK;
        endfunction

        function void flag(iee_pkg::status_t s);
            if (err == iee_pkg::ST_OK)
                err = s;
        endfunction

        function iee_pkg::op_t decode(logic [7:0] c);
            case (c)
                iee_pkg::ASCII_HASH:  return iee_pkg::OP_END;
                iee_pkg::ASCII_OPEN:  return iee_pkg::OP_OPEN;
                iee_pkg::ASCII_CLOSE: return iee_pkg::OP_CLOSE;
                iee_pkg::ASCII_ADD:   return iee_pkg::OP_ADD;
                iee_pkg::ASCII_SUB:   return iee_pkg::OP_SUB;
                iee_pkg::ASCII_MUL:   return iee_pkg::OP_MUL;
                iee_pkg::ASCII_DIV:   return iee_pkg::OP_DIV;
                default:              return iee_pkg::OP_NONE;
            endcase
        endfunction

        function int unsigned rank_stack(iee_pkg::op_t o);
            case (o)
                iee_pkg::OP_OPEN:                 return 1;
                iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 3;
                iee_pkg::OP_MUL, iee_pkg::OP_DIV: return 5;
                iee_pkg::OP_CLOSE:                return 6;
                default:                          return 0;
            endcase
        endfunction

        function int unsigned rank_in(iee_pkg::op_t o);
            case (o)
                iee_pkg::OP_OPEN:                 return 6;
                iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 2;
                iee_pkg::OP_MUL, iee_pkg::OP_DIV: return 4;
                iee_pkg::OP_CLOSE:                return 1;
                default:                          return 0;
            endcase
        endfunction

        function void push_val(logic [31:0] v);
            if (val_cnt >= 16)
                flag(iee_pkg::ST_OVER);
            else
            begin
                stk_val[val_cnt] = v;
                val_cnt++;
            end
        endfunction

        function void apply_top();
            iee_pkg::op_t o;
            logic signed [31:0] l, r;
            logic [31:0] lm, rm, q;
            op_cnt--;
            o = stk_op[op_cnt];
            if (val_cnt < 2)
            begin
                flag(iee_pkg::ST_UNDER);
                return;
            end
            r = stk_val[val_cnt-1];
            l = stk_val[val_cnt-2];
            val_cnt -= 2;
            case (o)
                iee_pkg::OP_ADD: push_val(l + r);
                iee_pkg::OP_SUB: push_val(l - r);
                iee_pkg::OP_MUL: push_val(l * r);
                iee_pkg::OP_DIV:
                begin
                    if (r == 0)
                    begin
                        flag(iee_pkg::ST_DIVZERO);
                        return;
                    end
                    lm = l[31] ? -l : l;
                    rm = r[31] ? -r : r;
                    q = lm / rm;
                    push_val((l[31] != r[31]) ? -q : q);
                end
                default: flag(iee_pkg::ST_BAD);
            endcase
        endfunction

        function void take_op(iee_pkg::op_t c);
            iee_pkg::op_t t;
            while (err == iee_pkg::ST_OK)
            begin
                t = stk_op[op_cnt-1];
                if (rank_stack(t) < rank_in(c))
                begin
                    if (c == iee_pkg::OP_CLOSE)
                        flag(iee_pkg::ST_BAD);
                    else if (op_cnt >= 16)
                        flag(iee_pkg::ST_OVER);
                    else
                    begin
                        stk_op[op_cnt] = c;
                        op_cnt++;
                    end
                    return;
                end
                if (rank_stack(t) == rank_in(c))
                begin
                    if (c != iee_pkg::OP_END)
                        op_cnt--;
                    return;
                end
                if (t == iee_pkg::OP_OPEN || t == iee_pkg::OP_END)
                begin
                    flag(iee_pkg::ST_BAD);
                    return;
                end
                apply_top();
            end
        endfunction

        function void note_char(logic [7:0] ch);
            iee_pkg::op_t c;
            logic [31:0]  d;
            c = decode(ch);
            d = 32'(ch - iee_pkg::ASCII_ZERO);
            if (c == iee_pkg::OP_END)
            begin
                if (err == iee_pkg::ST_OK)
                    take_op(iee_pkg::OP_END);
                if (err == iee_pkg::ST_OK && val_cnt == 0)
                    flag(iee_pkg::ST_UNDER);
                exp_result.push_back(err == iee_pkg::ST_OK ? stk_val[val_cnt-1] : 32'd0);
                exp_status.push_back(err);
                clear();
                return;
            end
            if (err != iee_pkg::ST_OK)
                return;
            if (ch >= iee_pkg::ASCII_ZERO && ch <= iee_pkg::ASCII_NINE)
            begin
                if (in_num && val_cnt > 0)
                    stk_val[val_cnt-1] = stk_val[val_cnt-1] * 32'd10 + d;
                else
                    push_val(d);
                in_num = 1;
                return;
            end
            in_num = 0;
            if (c == iee_pkg::OP_NONE)
                flag(iee_pkg::ST_BAD);
            else
                take_op(c);
        endfunction

        function void check_result(logic [31:0] v, logic [2:0] s);
            logic [31:0] ev;
            iee_pkg::status_t es;
            if (exp_result.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d status %0d", $signed(v), s);
                return;
            end
            ev = exp_result.pop_front();
            es = exp_status.pop_front();
            if (v !== ev || s !== es)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result exp %0d/%0d got %0d/%0d",
                             $signed(ev), es, $signed(v), s);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [7:0]  char_code;
    logic        in_valid;
    logic        in_ready;
    logic signed [31:0] result_value;
    logic [2:0]  status;
    logic        out_valid;
    logic        out_ready;

    expr_scoreboard sb;
    longint      cycles;
    int          hold_off;
    byte         text [$];

    infix_expression_evaluator u_dut (
        .clk(clk), .rst_n(rst_n), .char_code(char_code), .in_valid(in_valid),
        .in_ready(in_ready), .result_value(result_value), .status(status),
        .out_valid(out_valid), .out_ready(out_ready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic release_input();
        in_valid  <= 1'b0;
        char_code <= 8'($urandom);
    endtask

    task automatic send_char(logic [7:0] ch);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            release_input();
            repeat (gap)
                @(posedge clk);
        end
        char_code <= ch;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_char(ch);
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_char(s[i]);
    endtask

    task automatic add_number();
        int n;
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 15) == 0)
            n = $urandom_range(8, 12);
        repeat (n)
            text.push_back(8'(iee_pkg::ASCII_ZERO + 8'($urandom_range(0, 9))));
    endtask

    task automatic add_expr(int depth);
        byte ops [4] = '{iee_pkg::ASCII_ADD, iee_pkg::ASCII_SUB,
                         iee_pkg::ASCII_MUL, iee_pkg::ASCII_DIV};
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++)
        begin
            if (i > 0)
                text.push_back(ops[$urandom_range(0, 3)]);
            if (depth < 4 && $urandom_range(0, 3) == 0)
            begin
                text.push_back(iee_pkg::ASCII_OPEN);
                add_expr(depth + 1);
                text.push_back(iee_pkg::ASCII_CLOSE);
            end
            else
                add_number();
        end
    endtask

    task automatic send_random_expr();
        int k;
        text.delete();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8))
                text.push_back(8'($urandom_range(0, 255)));
        else
            add_expr(0);
        k = $urandom_range(0, 19);
        if (k == 0 && text.size() > 0)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
        else if (k == 1)
            text.insert($urandom_range(0, text.size()), iee_pkg::ASCII_OPEN);
        else if (k == 2)
            text.insert($urandom_range(0, text.size()), iee_pkg::ASCII_CLOSE);
        foreach (text[i])
            send_char(text[i]);
        send_char(iee_pkg::ASCII_HASH);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(result_value, status);
    end

    initial
    begin
        int w;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off)
                    @(posedge clk);
                hold_off = 0;
            end
            w = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                w = 0;
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("infix_expression_evaluator: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        sb = new();
        hold_off = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = 8'h00;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("2147483647+1#");
        send_text("0-2147483647-1/(0-1)#");
        send_text("7/0#");
        send_text("(1+2#");
        send_text("3)#");
        send_text("#");
        send_text("1+#");
        send_text("1 2#");
        send_text("4*5-9/2#");
        send_text("9999999999#");
        send_text("((((((((((((((((1#");
        send_text("1+2*3+4*5+6*7+8*9+1*2+3*4+5*6+7*8+1#");
        send_text("0-7/2#");
        send_text("1 2 3#");
        send_char(8'hFF);
        send_char(8'h00);
        send_char(iee_pkg::ASCII_HASH);

        hold_off = 300;
        repeat (5)
            send_random_expr();
        release_input();
        while (sb.exp_result.size() > 0)
            @(posedge clk);

        sent = 0;
        while (sent < 1350)
        begin
            send_random_expr();
            sent += text.size() + 1;
        end
        release_input();
        while (sb.exp_result.size() > 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.exp_result.size() == 0)
            $display("infix_expression_evaluator: match");
        else
            $display("infix_expression_evaluator: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/iee_pkg.sv
rtl/core/iee_div.sv
rtl/core/iee_dpath.sv
rtl/core/iee_ctrl.sv
rtl/core/infix_expression_evaluator.sv
bench/tb_infix_expression_evaluator.sv
